// ----- rtl/mau_pkg.sv -----
// Shared constants and control types of the modular arithmetic unit.
package mau_pkg;

	localparam int unsigned RES_W = 31;

	typedef logic [RES_W-1:0] res_t;

	localparam logic [2:0] CMD_REDUCE  = 3'd0;
	localparam logic [2:0] CMD_ADD     = 3'd1;
	localparam logic [2:0] CMD_SUB     = 3'd2;
	localparam logic [2:0] CMD_MUL     = 3'd3;
	localparam logic [2:0] CMD_DIV     = 3'd4;
	localparam logic [2:0] CMD_NEG     = 3'd5;
	localparam logic [2:0] CMD_POW     = 3'd6;
	localparam logic [2:0] CMD_INVERSE = 3'd7;

	localparam res_t RESET_MODULUS = 31'd1000000007;

	localparam logic REG_MODULUS = 1'b0;

	typedef struct packed {
		logic clr;
		logic step;
		logic dbit;
	} hrn_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

endpackage

// ----- rtl/mau_if.sv -----
// Valid/ready channel interfaces for commands and results.
interface mau_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [30:0]        operand_a;
	logic [30:0]        operand_b;
	logic signed [31:0] exponent;
	logic signed [63:0] raw_value;

	modport source (output valid, cmd, operand_a, operand_b, exponent, raw_value, input ready);
	modport sink (input valid, cmd, operand_a, operand_b, exponent, raw_value, output ready);
endinterface

interface mau_res_if;
	logic        valid;
	logic        ready;
	logic [30:0] result;
	logic        no_inverse;

	modport source (output valid, result, no_inverse, input ready);
	modport sink (input valid, result, no_inverse, output ready);
endinterface

// ----- rtl/mau_horner.sv -----
// Bit-serial modular accumulator: r = 2r + bit*mult mod m, one bit per cycle while ctl.step is high.
module mau_horner (
	input  logic              clk,
	input  mau_pkg::hrn_ctl_t ctl,
	input  mau_pkg::res_t     mult,
	input  mau_pkg::res_t     modulus,
	output mau_pkg::res_t     r
);
	import mau_pkg::*;

	res_t        r_q;
	logic [31:0] base;
	logic [31:0] dbl;
	logic [31:0] dred;
	logic [31:0] sum;
	logic [31:0] sred;
	logic [31:0] m32;

	always_comb begin
		m32  = {1'b0, modulus};
		base = ctl.clr ? 32'd0 : {1'b0, r_q};
		dbl  = {base[30:0], 1'b0};
		dred = (dbl >= m32) ? dbl - m32 : dbl;
		sum  = dred + (ctl.dbit ? {1'b0, mult} : 32'd0);
		sred = (sum >= m32) ? sum - m32 : sum;
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			r_q <= sred[30:0];
		end
	end

	assign r = r_q;
endmodule

// ----- rtl/mau_div.sv -----
// Restoring divider that produces one quotient bit per cycle while ctl.step is high, most significant first.
module mau_div (
	input  logic              clk,
	input  mau_pkg::div_ctl_t ctl,
	input  mau_pkg::res_t     dividend,
	input  mau_pkg::res_t     divisor,
	output logic              qbit,
	output mau_pkg::res_t     rem
);
	import mau_pkg::*;

	res_t        rem_q;
	res_t        dvd_q;
	res_t        dsr_q;
	logic [31:0] shifted;
	logic [31:0] diff;

	always_comb begin
		shifted = {rem_q, dvd_q[30]};
		diff    = shifted - {1'b0, dsr_q};
		qbit    = shifted >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (ctl.step) begin
			rem_q <= qbit ? diff[30:0] : shifted[30:0];
			dvd_q <= {dvd_q[29:0], 1'b0};
		end
	end

	assign rem = rem_q;
endmodule

// ----- rtl/modular_arithmetic_unit.sv -----
// Top level of the modular arithmetic unit: sequencer, modulus register and serial units.
//
//  channel  | role   | payload
//  ---------+--------+----------------------------------------------
//  req      | sink   | cmd, operand_a, operand_b, exponent, raw_value
//  rsp      | source | result, no_inverse
//  apb      | slave  | modulus at byte address 0
//
// One transaction at a time; every multiply or reduction runs one bit per cycle.
// After acceptance both operands are reduced; add, sub and neg then finish,
// mul adds a multiply, reduce a pass over the raw value, divide Euclid steps and a multiply.
// Pow squares per exponent bit and multiplies per one bit; inverse runs Euclid steps.
// Reset is asynchronous; a stalled result is held and the next command is still taken.
module modular_arithmetic_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	mau_cmd_if.sink      req,
	mau_res_if.source    rsp
);
	import mau_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RUN   = 4'd1;
	localparam logic [3:0] S_NEXT  = 4'd2;
	localparam logic [3:0] S_PSTEP = 4'd3;
	localparam logic [3:0] S_EULD  = 4'd4;
	localparam logic [3:0] S_EUDIV = 4'd5;
	localparam logic [3:0] S_EUUPD = 4'd6;
	localparam logic [3:0] S_DONE  = 4'd7;

	localparam logic [2:0] PH_REDA = 3'd0;
	localparam logic [2:0] PH_REDB = 3'd1;
	localparam logic [2:0] PH_RAW  = 3'd2;
	localparam logic [2:0] PH_FIN  = 3'd3;
	localparam logic [2:0] PH_PMUL = 3'd4;
	localparam logic [2:0] PH_PSQ  = 3'd5;

	res_t        mod_q;
	res_t        m_eff;
	logic        m_one;
	res_t        one_v;
	logic [31:0] m32;

	logic [3:0]  state_q;
	logic [2:0]  ph_q;
	logic [2:0]  cmd_q;
	res_t        bin_q;
	res_t        exp_q;
	logic        neg_q;
	logic [63:0] sh_q;
	logic [6:0]  cnt_q;
	logic        fst_q;
	res_t        hv_q;
	res_t        a_q;
	res_t        r_q;
	res_t        t_q;
	res_t        eu_a_q;
	res_t        eu_b_q;
	res_t        eu_u_q;
	res_t        eu_v_q;
	res_t        res_q;
	logic        bad_q;
	logic        ovld_q;
	res_t        ores_q;
	logic        obad_q;

	hrn_ctl_t    hctl;
	div_ctl_t    dctl;
	res_t        hr;
	logic        qbit;
	res_t        drem;
	logic [31:0] add_s;
	logic [31:0] sub_s;
	res_t        neg_s;
	logic [31:0] upd_v;
	logic        gcd_bad;
	logic        wr_en;
	logic [63:0] raw_mag;

	always_comb begin
		m_eff   = (mod_q == '0) ? 31'd1 : mod_q;
		m_one   = (m_eff == 31'd1);
		one_v   = m_one ? 31'd0 : 31'd1;
		m32     = {1'b0, m_eff};
		add_s   = {1'b0, a_q} + {1'b0, hr};
		if (add_s >= m32) begin
			add_s = add_s - m32;
		end
		sub_s   = (a_q >= hr) ? {1'b0, a_q} - {1'b0, hr} : {1'b0, a_q} + m32 - {1'b0, hr};
		neg_s   = (a_q == '0) ? 31'd0 : m_eff - a_q;
		upd_v   = (eu_u_q >= hr) ? {1'b0, eu_u_q} - {1'b0, hr}
		                         : {1'b0, eu_u_q} + m32 - {1'b0, hr};
		gcd_bad = (eu_b_q != 31'd1) && !m_one;
		raw_mag = req.raw_value[63] ? (~req.raw_value) + 64'd1 : req.raw_value;
		wr_en   = psel && penable && pwrite;

		hctl.clr  = fst_q;
		hctl.step = (state_q == S_RUN) || (state_q == S_EUDIV);
		hctl.dbit = (state_q == S_EUDIV) ? qbit : sh_q[63];
		dctl.load = (state_q == S_EULD);
		dctl.step = (state_q == S_EUDIV);
	end

	mau_horner u_horner (
		.clk     (clk),
		.ctl     (hctl),
		.mult    (hv_q),
		.modulus (m_eff),
		.r       (hr)
	);

	mau_div u_div (
		.clk      (clk),
		.ctl      (dctl),
		.dividend (eu_a_q),
		.divisor  (eu_b_q),
		.qbit     (qbit),
		.rem      (drem)
	);

	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_MODULUS) ? {1'b0, mod_q} : 32'd0;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = ovld_q;
	assign rsp.result = ores_q;
	assign rsp.no_inverse = obad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= RESET_MODULUS;
		end else if (wr_en && (paddr[2] == REG_MODULUS)) begin
			mod_q <= pwdata[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= PH_REDA;
			cmd_q   <= CMD_REDUCE;
			bin_q   <= '0;
			exp_q   <= '0;
			neg_q   <= 1'b0;
			sh_q    <= '0;
			cnt_q   <= '0;
			fst_q   <= 1'b0;
			hv_q    <= '0;
			a_q     <= '0;
			r_q     <= '0;
			t_q     <= '0;
			eu_a_q  <= '0;
			eu_b_q  <= '0;
			eu_u_q  <= '0;
			eu_v_q  <= '0;
			res_q   <= '0;
			bad_q   <= 1'b0;
			ovld_q  <= 1'b0;
			ores_q  <= '0;
			obad_q  <= 1'b0;
		end else begin
			if (ovld_q && rsp.ready && (state_q != S_DONE)) begin
				ovld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q   <= req.cmd;
						bin_q   <= req.operand_b;
						exp_q   <= req.exponent[31] ? 31'd0 : req.exponent[30:0];
						neg_q   <= req.raw_value[63];
						bad_q   <= 1'b0;
						sh_q    <= {req.operand_a, 33'd0};
						eu_a_q  <= raw_mag[30:0];
						t_q     <= raw_mag[61:31];
						r_q     <= {28'd0, raw_mag[63:62], 1'b0};
						res_q   <= '0;
						eu_u_q  <= '0;
						eu_v_q  <= '0;
						eu_b_q  <= '0;
						a_q     <= '0;
						hv_q    <= one_v;
						cnt_q   <= 7'd31;
						fst_q   <= 1'b1;
						ph_q    <= PH_REDA;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					sh_q  <= {sh_q[62:0], 1'b0};
					fst_q <= 1'b0;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					case (ph_q)
						PH_REDA: begin
							a_q     <= hr;
							sh_q    <= {bin_q, 33'd0};
							hv_q    <= one_v;
							cnt_q   <= 7'd31;
							fst_q   <= 1'b1;
							ph_q    <= PH_REDB;
							state_q <= S_RUN;
						end
						PH_REDB: begin
							case (cmd_q)
								CMD_REDUCE: begin
									sh_q    <= {r_q[2:1], t_q, eu_a_q};
									hv_q    <= one_v;
									cnt_q   <= 7'd64;
									fst_q   <= 1'b1;
									ph_q    <= PH_RAW;
									state_q <= S_RUN;
								end
								CMD_ADD: begin
									res_q   <= add_s[30:0];
									state_q <= S_DONE;
								end
								CMD_SUB: begin
									res_q   <= sub_s[30:0];
									state_q <= S_DONE;
								end
								CMD_NEG: begin
									res_q   <= neg_s;
									state_q <= S_DONE;
								end
								CMD_MUL: begin
									sh_q    <= {hr, 33'd0};
									hv_q    <= a_q;
									cnt_q   <= 7'd31;
									fst_q   <= 1'b1;
									ph_q    <= PH_FIN;
									state_q <= S_RUN;
								end
								CMD_POW: begin
									r_q     <= one_v;
									t_q     <= a_q;
									state_q <= S_PSTEP;
								end
								CMD_DIV: begin
									eu_a_q  <= hr;
									eu_b_q  <= m_eff;
									eu_u_q  <= one_v;
									eu_v_q  <= '0;
									state_q <= S_EULD;
								end
								default: begin
									eu_a_q  <= a_q;
									eu_b_q  <= m_eff;
									eu_u_q  <= one_v;
									eu_v_q  <= '0;
									state_q <= S_EULD;
								end
							endcase
						end
						PH_RAW: begin
							res_q   <= (neg_q && (hr != '0)) ? m_eff - hr : hr;
							state_q <= S_DONE;
						end
						PH_PMUL: begin
							r_q     <= hr;
							sh_q    <= {t_q, 33'd0};
							hv_q    <= t_q;
							cnt_q   <= 7'd31;
							fst_q   <= 1'b1;
							ph_q    <= PH_PSQ;
							state_q <= S_RUN;
						end
						PH_PSQ: begin
							t_q     <= hr;
							exp_q   <= {1'b0, exp_q[30:1]};
							state_q <= S_PSTEP;
						end
						default: begin
							res_q   <= hr;
							state_q <= S_DONE;
						end
					endcase
				end
				S_PSTEP: begin
					if (exp_q == '0) begin
						res_q   <= r_q;
						state_q <= S_DONE;
					end else begin
						sh_q    <= {t_q, 33'd0};
						hv_q    <= exp_q[0] ? r_q : t_q;
						cnt_q   <= 7'd31;
						fst_q   <= 1'b1;
						ph_q    <= exp_q[0] ? PH_PMUL : PH_PSQ;
						state_q <= S_RUN;
					end
				end
				S_EULD: begin
					hv_q    <= eu_v_q;
					cnt_q   <= 7'd31;
					fst_q   <= 1'b1;
					state_q <= S_EUDIV;
				end
				S_EUDIV: begin
					fst_q <= 1'b0;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						state_q <= S_EUUPD;
					end
				end
				S_EUUPD: begin
					eu_a_q <= eu_b_q;
					eu_b_q <= drem;
					eu_u_q <= eu_v_q;
					eu_v_q <= upd_v[30:0];
					if (drem != '0) begin
						state_q <= S_EULD;
					end else if (gcd_bad) begin
						bad_q   <= 1'b1;
						res_q   <= '0;
						state_q <= S_DONE;
					end else if (cmd_q == CMD_DIV) begin
						sh_q    <= {eu_v_q, 33'd0};
						hv_q    <= a_q;
						cnt_q   <= 7'd31;
						fst_q   <= 1'b1;
						ph_q    <= PH_FIN;
						state_q <= S_RUN;
					end else begin
						res_q   <= eu_v_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!ovld_q || rsp.ready) begin
						ovld_q  <= 1'b1;
						ores_q  <= res_q;
						obad_q  <= bad_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ----- rtl/mau_chk.sv -----
// Port-level assertions for the modular arithmetic unit, bound to the top level.
module mau_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [30:0] result,
	input logic        no_inverse
);
	import mau_pkg::*;

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result) && $stable(no_inverse))
		else $error("stalled result changed");

	a_noinv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && no_inverse |-> result == '0)
		else $error("result nonzero with no_inverse");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready right after an accepted transaction");

	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !($rose(rsp_valid)))
		else $error("result appeared without computation");
endmodule

bind modular_arithmetic_unit mau_chk u_mau_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.pready     (pready),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.result     (rsp.result),
	.no_inverse (rsp.no_inverse)
);

// ----- test/modular_arithmetic_unit_scoreboard.sv -----
// Scoreboard class that predicts and checks results of the modular arithmetic unit.
`timescale 1ns / 1ps

class mau_scoreboard;
	logic [30:0] modulus;
	logic [30:0] pending_result[$];
	logic        pending_no_inv[$];
	int          errors;

	function void reset_state();
		modulus = mau_pkg::RESET_MODULUS;
		pending_result.delete();
		pending_no_inv.delete();
		errors = 0;
	endfunction

	function longint unsigned reduce_signed(longint v, longint unsigned m);
		longint unsigned mag;
		longint unsigned r;
		if (v >= 0)
			return longint'(unsigned'(v)) % m;
		mag = 64'd0 - longint'(unsigned'(v));
		r = mag % m;
		return (r == 0) ? 0 : m - r;
	endfunction

	function longint unsigned inverse_of(longint unsigned x, longint unsigned m,
			output bit bad);
		longint a;
		longint b;
		longint u;
		longint v;
		longint q;
		longint t;
		a = x % m;
		b = m;
		u = 1;
		v = 0;
		while (b > 0) begin
			q = a / b;
			a = a - q * b;
			t = a; a = b; b = t;
			u = u - q * v;
			t = u; u = v; v = t;
		end
		if (a != 1 && m != 1) begin
			bad = 1;
			return 0;
		end
		bad = 0;
		return reduce_signed(u, m);
	endfunction

	function void note_command(logic [2:0] cmd, logic [30:0] op_a, logic [30:0] op_b,
			logic signed [31:0] expo, logic signed [63:0] raw);
		longint unsigned m;
		longint unsigned a;
		longint unsigned b;
		longint unsigned res;
		longint unsigned base;
		longint unsigned iv;
		logic [31:0] n;
		bit bad;
		m = (modulus == 0) ? 1 : modulus;
		a = op_a % m;
		b = op_b % m;
		res = 0;
		bad = 0;
		case (cmd)
			mau_pkg::CMD_REDUCE: res = reduce_signed(raw, m);
			mau_pkg::CMD_ADD: begin
				res = a + b;
				if (res >= m)
					res -= m;
			end
			mau_pkg::CMD_SUB: res = (a + m - b) % m;
			mau_pkg::CMD_MUL: res = (a * b) % m;
			mau_pkg::CMD_DIV: begin
				iv = inverse_of(b, m, bad);
				res = bad ? 0 : (a * iv) % m;
			end
			mau_pkg::CMD_NEG: res = (m - a) % m;
			mau_pkg::CMD_POW: begin
				n = expo[31] ? 32'd0 : expo;
				base = a;
				res = 1 % m;
				while (n > 0) begin
					if (n[0])
						res = (res * base) % m;
					base = (base * base) % m;
					n = n >> 1;
				end
			end
			default: res = inverse_of(a, m, bad);
		endcase
		pending_result.push_back(res[30:0]);
		pending_no_inv.push_back(bad);
	endfunction

	function void check_result(logic [30:0] result, logic no_inverse);
		logic [30:0] exp_res;
		logic exp_ni;
		if (pending_result.size() == 0) begin
			$display("%0t: unexpected result expected none actual %0d/%0b", $time,
				result, no_inverse);
			errors++;
			return;
		end
		exp_res = pending_result.pop_front();
		exp_ni = pending_no_inv.pop_front();
		if (result !== exp_res) begin
			$display("%0t: result expected %0d actual %0d", $time, exp_res, result);
			errors++;
		end
		if (no_inverse !== exp_ni) begin
			$display("%0t: no_inverse expected %0b actual %0b", $time, exp_ni, no_inverse);
			errors++;
		end
	endfunction
endclass

// ----- test/modular_arithmetic_unit_test.sv -----
// Top-level testbench of the modular arithmetic unit with directed and random traffic.
`timescale 1ns / 1ps

module modular_arithmetic_unit_test;
	import mau_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          send_idle_pct;
	int          recv_stall_pct;
	longint      cycles;

	mau_cmd_if req ();
	mau_res_if rsp ();

	mau_scoreboard board;

	modular_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req.sink), .rsp(rsp.source)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 64'd12000000) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			board.check_result(rsp.result, rsp.no_inverse);
	end

	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_modulus(logic [30:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 3'd0;
		pwdata <= {1'b0, value};
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		board.modulus = value;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic send_command(logic [2:0] cmd, logic [30:0] a, logic [30:0] b,
			logic signed [31:0] expo, logic signed [63:0] raw);
		do
			@(negedge clk);
		while ($urandom_range(99) < send_idle_pct);
		req.valid <= 1;
		req.cmd <= cmd;
		req.operand_a <= a;
		req.operand_b <= b;
		req.exponent <= expo;
		req.raw_value <= raw;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		board.note_command(cmd, a, b, expo, raw);
		@(negedge clk);
		req.valid <= 0;
	endtask

	task automatic drain();
		while (board.pending_result.size() != 0)
			@(negedge clk);
		repeat (2500)
			@(negedge clk);
	endtask

	function automatic logic [30:0] pick_operand(logic [30:0] m);
		case ($urandom_range(5))
			0: return 31'd0;
			1: return 31'h7fffffff;
			2: return m - 31'd1;
			3: return m;
			default: return 31'($urandom());
		endcase
	endfunction

	task automatic random_phase(int count);
		logic [30:0] m;
		logic [2:0] cmd;
		logic signed [31:0] expo;
		m = board.modulus;
		repeat (count) begin
			cmd = 3'($urandom_range(7));
			expo = $urandom();
			if (cmd == CMD_POW && $urandom_range(3) != 0)
				expo = $urandom_range(4096) - 64;
			send_command(cmd, pick_operand(m), pick_operand(m), expo,
				{$urandom(), $urandom()});
		end
	endtask

	initial begin
		logic [30:0] moduli[6];
		board = new();
		board.reset_state();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		req.valid = 0;
		req.cmd = CMD_REDUCE;
		req.operand_a = 0;
		req.operand_b = 0;
		req.exponent = 0;
		req.raw_value = 0;
		rsp.ready = 0;
		repeat (8)
			@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_command(CMD_REDUCE, 0, 0, 0, 64'sh8000000000000000);
		send_command(CMD_REDUCE, 0, 0, 0, 64'sh7fffffffffffffff);
		send_command(CMD_REDUCE, 0, 0, 0, -64'sd1000000007);
		send_command(CMD_ADD, 31'h7fffffff, 1000000006, 0, 0);
		send_command(CMD_SUB, 0, 31'h7fffffff, 0, 0);
		send_command(CMD_MUL, 1000000006, 1000000006, 0, 0);
		send_command(CMD_DIV, 5, 0, 0, 0);
		send_command(CMD_DIV, 31'h7fffffff, 3, 0, 0);
		send_command(CMD_NEG, 0, 0, 0, 0);
		send_command(CMD_NEG, 31'h7fffffff, 0, 0, 0);
		send_command(CMD_POW, 2, 0, 32'sh7fffffff, 0);
		send_command(CMD_POW, 2, 0, 32'sh80000000, 0);
		send_command(CMD_POW, 7, 0, 0, 0);
		send_command(CMD_INVERSE, 0, 0, 0, 0);
		send_command(CMD_INVERSE, 31'h7fffffff, 0, 0, 0);
		drain();
		write_modulus(0);
		send_command(CMD_POW, 3, 0, 5, 0);
		send_command(CMD_INVERSE, 3, 0, 0, 0);
		drain();
		write_modulus(1);
		send_command(CMD_POW, 3, 0, -1, 0);
		send_command(CMD_INVERSE, 0, 0, 0, 0);
		send_command(CMD_DIV, 4, 0, 0, 0);
		drain();
		write_modulus(12);
		send_command(CMD_INVERSE, 6, 0, 0, 0);
		send_command(CMD_DIV, 5, 7, 0, 0);
		drain();

		moduli[0] = 31'h7fffffff;
		moduli[1] = 31'd1000000007;
		moduli[2] = 31'd97;
		moduli[3] = 31'd998244353;
		moduli[4] = 31'd360;
		moduli[5] = 31'h7ffffffe;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 74; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 74; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			write_modulus(ph < 6 ? moduli[ph] : 31'($urandom()));
			random_phase(50);
			drain();
			random_phase(50);
			drain();
		end

		if (board.errors == 0 && board.pending_result.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
